// ----- rtl/rtfs_pkg.sv -----
// Shared types and constants for the ready-first thread scheduler.
`timescale 1ns / 1ps

package rtfs_pkg;

   localparam int OP_W       = 2;
   localparam int SLOT_W     = 6;
   localparam int TICK_W     = 31;
   localparam int STATUS_W   = 2;
   localparam int DEADLINE_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER = 2'd0,
      OP_SLEEP    = 2'd1,
      OP_SCHEDULE = 2'd2,
      OP_EXIT     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_EMPTY = 2'd0,
      ST_READY = 2'd1,
      ST_SLEEP = 2'd2,
      ST_EXIT  = 2'd3
   } slot_status_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_OP     = 3'd1,
      S_START  = 3'd2,
      S_SCAN   = 3'd3,
      S_FINISH = 3'd4
   } state_type;

   typedef struct packed {
      logic load_item;
      logic do_op;
      logic scan_start;
      logic scan_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } stat_type;

endpackage

// ----- rtl/ready_first_thread_scheduler.sv -----
// Top level of the ready-first thread scheduler.
// Usage:
//   One request item carries an operation (register slot, sleep current,
//   schedule only, exit current), a slot index, the current tick and a
//   sleep duration. Each item yields exactly one result item: the slot that
//   was current, the slot chosen next and a flag set when idle slot 0 won.
//   Both channels are valid/ready; an item moves when valid and ready are high.
// Sequence:
//   An item is taken only while the sequencer is idle. It applies its
//   operation in S_OP, primes the slot table read in S_START and then
//   checks one slot per S_SCAN step, from slot 1 up to the chosen slot, the
//   first empty slot or the last slot. S_FINISH loads the result register;
//   the next item is taken only once the sequencer is back in S_IDLE, so a
//   new item never overlaps the last. The per-slot scan over the single read
//   port of the slot table bounds how fast items are worked.
// Reset and stalls:
//   Reset empties every slot at once through per-slot valid flags and makes
//   the idle slot current. A stalled result sits in the output register while
//   the next item is accepted and worked; that item then holds before its
//   result stage until the output register is taken.
`timescale 1ns / 1ps

module ready_first_thread_scheduler #(
   parameter int THREAD_SLOTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rtfs_pkg::OP_W-1:0]   req_operation,
   input  logic [rtfs_pkg::SLOT_W-1:0] req_slot,
   input  logic [rtfs_pkg::TICK_W-1:0] req_tick,
   input  logic [rtfs_pkg::TICK_W-1:0] req_duration,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rtfs_pkg::SLOT_W-1:0] rsp_previous_thread,
   output logic [rtfs_pkg::SLOT_W-1:0] rsp_next_thread,
   output logic                        rsp_went_idle
);

   rtfs_pkg::cmd_type  cmd;
   rtfs_pkg::stat_type stat;

   rtfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rtfs_datapath #(
      .THREAD_SLOTS (THREAD_SLOTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_operation       (req_operation),
      .req_slot            (req_slot),
      .req_tick            (req_tick),
      .req_duration        (req_duration),
      .rsp_previous_thread (rsp_previous_thread),
      .rsp_next_thread     (rsp_next_thread),
      .rsp_went_idle       (rsp_went_idle)
   );

endmodule

// ----- rtl/rtfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rtfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rtfs_ctrl.sv -----
// Sequencer for one scheduling item: apply operation, scan slots, deliver result.
`timescale 1ns / 1ps

module rtfs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  rtfs_pkg::stat_type stat,
   output rtfs_pkg::cmd_type  cmd
);

   rtfs_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtfs_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rtfs_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = rtfs_pkg::S_OP;
            end
         end
         rtfs_pkg::S_OP: begin
            cmd.do_op = 1'b1;
            state_in  = rtfs_pkg::S_START;
         end
         rtfs_pkg::S_START: begin
            cmd.scan_start = 1'b1;
            state_in       = rtfs_pkg::S_SCAN;
         end
         rtfs_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = rtfs_pkg::S_FINISH;
            end
         end
         rtfs_pkg::S_FINISH: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = rtfs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rtfs_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == rtfs_pkg::S_SCAN |->
         ($past(state_ff) == rtfs_pkg::S_START || $past(state_ff) == rtfs_pkg::S_SCAN))
      else $error("scan entered without start");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> state_ff == rtfs_pkg::S_OP)
      else $error("accepted item did not reach operation step");

endmodule

// ----- rtl/rtfs_datapath.sv -----
// Slot tables, item registers, scan pointer and result registers.
`timescale 1ns / 1ps

module rtfs_datapath #(
   parameter int THREAD_SLOTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rtfs_pkg::cmd_type             cmd,
   output rtfs_pkg::stat_type            stat,
   input  logic [rtfs_pkg::OP_W-1:0]     req_operation,
   input  logic [rtfs_pkg::SLOT_W-1:0]   req_slot,
   input  logic [rtfs_pkg::TICK_W-1:0]   req_tick,
   input  logic [rtfs_pkg::TICK_W-1:0]   req_duration,
   output logic [rtfs_pkg::SLOT_W-1:0]   rsp_previous_thread,
   output logic [rtfs_pkg::SLOT_W-1:0]   rsp_next_thread,
   output logic                          rsp_went_idle
);

   localparam int IW    = $clog2(THREAD_SLOTS);
   localparam int CMP_W = 9;

   rtfs_pkg::op_type              op_ff;
   logic [rtfs_pkg::SLOT_W-1:0]   slot_ff;
   logic [rtfs_pkg::TICK_W-1:0]   tick_ff;
   logic [rtfs_pkg::TICK_W-1:0]   dur_ff;
   logic [IW-1:0]                 prev_ff;
   logic [IW-1:0]                 current_ff;
   logic [IW-1:0]                 chk_ff;
   logic [IW-1:0]                 found_ff;
   logic [THREAD_SLOTS-1:0]       valid_ff;
   logic [rtfs_pkg::SLOT_W-1:0]   rsp_prev_ff;
   logic [rtfs_pkg::SLOT_W-1:0]   rsp_next_ff;
   logic                          rsp_idle_ff;

   logic                              wr_en;
   logic [IW-1:0]                     wr_addr;
   rtfs_pkg::slot_status_type         wr_status;
   logic                              dl_wr_en;
   logic [rtfs_pkg::DEADLINE_W-1:0]   deadline_sum;
   logic                              slot_in_range;
   logic [IW-1:0]                     rd_addr;
   logic [rtfs_pkg::STATUS_W-1:0]     status_rd;
   logic [rtfs_pkg::DEADLINE_W-1:0]   dl_rd;
   logic [rtfs_pkg::DEADLINE_W-1:0]   tick_ext;
   logic                              entry_valid;
   rtfs_pkg::slot_status_type         entry_status;
   logic                              wake;
   logic                              hit;
   logic                              last;

   assign deadline_sum  = {1'b0, tick_ff} + {1'b0, dur_ff};
   assign tick_ext      = {1'b0, tick_ff};
   assign slot_in_range = (slot_ff != '0) &&
                          ({3'b000, slot_ff} < CMP_W'(THREAD_SLOTS));

   // scan check on the entry read in the previous cycle
   assign entry_valid  = valid_ff[chk_ff];
   assign entry_status = entry_valid ? rtfs_pkg::slot_status_type'(status_rd)
                                     : rtfs_pkg::ST_EMPTY;
   assign wake = (entry_status == rtfs_pkg::ST_SLEEP) &&
                 ($signed(tick_ext) > $signed(dl_rd));
   assign hit  = (entry_status == rtfs_pkg::ST_READY) || wake;
   assign last = chk_ff == IW'(THREAD_SLOTS - 1);
   assign stat.scan_done = !entry_valid || hit || last;

   // read ahead one slot while the current one is checked
   assign rd_addr = cmd.scan_start ? IW'(1) : chk_ff + IW'(1);

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = prev_ff;
      wr_status = rtfs_pkg::ST_READY;
      dl_wr_en  = 1'b0;
      if (cmd.do_op) begin
         unique case (op_ff)
            rtfs_pkg::OP_REGISTER: begin
               if (slot_in_range) begin
                  wr_en   = 1'b1;
                  wr_addr = IW'(slot_ff);
               end
            end
            rtfs_pkg::OP_SLEEP: begin
               if (prev_ff != '0 && valid_ff[prev_ff]) begin
                  wr_en     = 1'b1;
                  wr_status = rtfs_pkg::ST_SLEEP;
                  dl_wr_en  = 1'b1;
               end
            end
            rtfs_pkg::OP_SCHEDULE: begin
            end
            rtfs_pkg::OP_EXIT: begin
               if (prev_ff != '0) begin
                  wr_en     = 1'b1;
                  wr_status = rtfs_pkg::ST_EXIT;
               end
            end
         endcase
      end else if (cmd.scan_step && wake) begin
         wr_en   = 1'b1;
         wr_addr = chk_ff;
      end
   end

   rtfs_ram #(
      .WIDTH (rtfs_pkg::STATUS_W),
      .DEPTH (THREAD_SLOTS)
   ) u_status_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_status),
      .rd_addr (rd_addr),
      .rd_data (status_rd)
   );

   rtfs_ram #(
      .WIDTH (rtfs_pkg::DEADLINE_W),
      .DEPTH (THREAD_SLOTS)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_wr_en),
      .wr_addr (prev_ff),
      .wr_data (deadline_sum),
      .rd_addr (rd_addr),
      .rd_data (dl_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         current_ff <= '0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.load_rsp) begin
            current_ff <= found_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= rtfs_pkg::op_type'(req_operation);
         slot_ff <= req_slot;
         tick_ff <= req_tick;
         dur_ff  <= req_duration;
         prev_ff <= current_ff;
      end
      if (cmd.scan_start) begin
         chk_ff <= IW'(1);
      end else if (cmd.scan_step) begin
         chk_ff <= chk_ff + IW'(1);
      end
      if (cmd.scan_step && stat.scan_done) begin
         found_ff <= hit ? chk_ff : '0;
      end
      if (cmd.load_rsp) begin
         rsp_prev_ff <= rtfs_pkg::SLOT_W'(prev_ff);
         rsp_next_ff <= rtfs_pkg::SLOT_W'(found_ff);
         rsp_idle_ff <= found_ff == '0;
      end
   end

   assign rsp_previous_thread = rsp_prev_ff;
   assign rsp_next_thread     = rsp_next_ff;
   assign rsp_went_idle       = rsp_idle_ff;

   a_current_occupied: assert property (@(posedge clock) disable iff (reset)
      current_ff != '0 |-> valid_ff[current_ff])
      else $error("current slot is empty");

endmodule
